@@ design/asr_pkg.sv @@
`timescale 1ns / 1ps
package asr_pkg;

	// sizing
	localparam int unsigned MAX_RADIUS     = 255;
	localparam int unsigned COORD_BITS_DEF = 12;
	localparam int unsigned RADIUS_BITS    = 8;
	localparam int unsigned RAD_SQ_BITS    = 2 * RADIUS_BITS;
	localparam int unsigned ROOT_STEPS     = RADIUS_BITS;
	localparam int unsigned RGB_BITS       = 24;
	localparam int unsigned COLOUR_BITS    = 16;
	localparam int unsigned ADDR_BITS      = 5;
	localparam int unsigned DATA_BITS      = 32;
	localparam int unsigned REG_IDX_BITS   = ADDR_BITS - 2;
	localparam int unsigned QUEUE_DEPTH    = 2;
	localparam int unsigned SPAN_IDX_BITS  = 2;

	// register map, word index
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_CTR_COL,
		REG_CTR_ROW,
		REG_HOLE_RAD,
		REG_RIM_RAD,
		REG_FILL_RGB
	} reg_index_t;

	// back-end sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROOT_OUTER,
		BK_ROOT_INNER,
		BK_EMIT
	} back_state_t;

	// one classified row on its way from front to back
	typedef struct packed {
		logic [RADIUS_BITS-1:0] dy;
		logic                   use_inner;
		logic [RAD_SQ_BITS-1:0] rad_outer;
		logic [RAD_SQ_BITS-1:0] rad_inner;
	} row_job_t;

	function automatic logic [RADIUS_BITS-1:0] clamp_radius(input logic [RADIUS_BITS-1:0] r);
		logic [RADIUS_BITS-1:0] c;
		if (32'(r) > MAX_RADIUS) c = RADIUS_BITS'(MAX_RADIUS);
		else c = r;
		return c;
	endfunction

	// opaque RGB555: keep the top five bits of each channel
	function automatic logic [COLOUR_BITS-1:0] pack_rgb555(input logic [RGB_BITS-1:0] rgb);
		return {1'b1, rgb[23:19], rgb[15:11], rgb[7:3]};
	endfunction

endpackage

@@ design/asr_isqrt.sv @@
`timescale 1ns / 1ps
module asr_isqrt import asr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [RAD_SQ_BITS-1:0] radicand,
	output logic                   done,
	output logic [RADIUS_BITS-1:0] root
);

	localparam int unsigned CNT_W   = (ROOT_STEPS > 1) ? $clog2(ROOT_STEPS) : 1;
	localparam int unsigned REM_Q_W = RADIUS_BITS + 1;
	localparam int unsigned REM_W   = RADIUS_BITS + 3;

	logic [RAD_SQ_BITS-1:0] rad_q;
	logic [REM_Q_W-1:0]     rem_q;
	logic [RADIUS_BITS-1:0] root_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             fits;
	logic             last_step;

	// one result bit per step: bring down two radicand bits, try 4*root+1
	always_comb begin
		rem_sh    = {rem_q, rad_q[RAD_SQ_BITS-1 -: 2]};
		trial     = {1'b0, root_q, 2'b01};
		fits      = (rem_sh >= trial);
		last_step = (cnt_q == CNT_W'(ROOT_STEPS - 1));
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_step) busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_SQ_BITS-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_Q_W'(rem_sh - trial);
				root_q <= {root_q[RADIUS_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= REM_Q_W'(rem_sh);
				root_q <= {root_q[RADIUS_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ design/asr_queue.sv @@
`timescale 1ns / 1ps
module asr_queue import asr_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  row_job_t push_data,
	input  logic     pop,
	output logic     valid,
	output logic     full,
	output row_job_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	row_job_t         entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(DEPTH - 1)) n = '0;
		else n = p + PTR_W'(1);
		return n;
	endfunction

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

	assign valid = (count_q != '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = entries_q[rd_ptr_q];

endmodule

@@ design/asr_front.sv @@
`timescale 1ns / 1ps
module asr_front import asr_pkg::*; (
	input  logic                   row_valid,
	input  logic [RADIUS_BITS-1:0] row_offset,
	output logic                   row_stall,
	input  logic [RADIUS_BITS-1:0] hole_rad,
	input  logic [RADIUS_BITS-1:0] rim_rad,
	input  logic                   q_full,
	output logic                   push,
	output row_job_t               job
);

	logic [RADIUS_BITS-1:0] outer_c;
	logic [RADIUS_BITS-1:0] inner_c;
	logic [RAD_SQ_BITS-1:0] dy_sq;
	logic [RAD_SQ_BITS-1:0] outer_sq;
	logic [RAD_SQ_BITS-1:0] inner_sq;
	logic                   no_spans;

	// classify the row and form both radicands
	always_comb begin
		outer_c  = clamp_radius(rim_rad);
		inner_c  = clamp_radius(hole_rad);
		dy_sq    = RAD_SQ_BITS'(row_offset) * RAD_SQ_BITS'(row_offset);
		outer_sq = RAD_SQ_BITS'(outer_c) * RAD_SQ_BITS'(outer_c);
		inner_sq = RAD_SQ_BITS'(inner_c) * RAD_SQ_BITS'(inner_c);
		// empty ring, or row outside it
		no_spans = (outer_c == '0) || (inner_c >= outer_c) || (row_offset > outer_c);

		job.dy        = row_offset;
		job.use_inner = (row_offset <= inner_c);
		job.rad_outer = outer_sq - dy_sq;
		job.rad_inner = inner_sq - dy_sq;
	end

	// rows with nothing to draw are taken and dropped here
	assign row_stall = q_full;
	assign push      = row_valid && !q_full && !no_spans;

endmodule

@@ design/asr_back.sv @@
`timescale 1ns / 1ps
module asr_back import asr_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	input  row_job_t               job,
	output logic                   job_pop,
	input  logic [COORD_BITS-1:0]  ctr_col,
	input  logic [COORD_BITS-1:0]  ctr_row,
	input  logic [COLOUR_BITS-1:0] colour,
	output logic                   span_valid,
	input  logic                   span_stall,
	output logic [COORD_BITS:0]    span_x_start,
	output logic [COORD_BITS:0]    span_x_end,
	output logic [COORD_BITS:0]    span_row,
	output logic [COLOUR_BITS-1:0] span_colour,
	output logic                   last_span
);

	localparam int unsigned W = COORD_BITS + 1;

	back_state_t state_q, state_d;

	row_job_t               job_q;
	logic [RADIUS_BITS-1:0] ox_q;
	logic [RADIUS_BITS-1:0] ix_q;
	logic [SPAN_IDX_BITS-1:0] k_q;

	logic                   out_valid_q;
	logic [W-1:0]           xs_q;
	logic [W-1:0]           xe_q;
	logic [W-1:0]           row_q;
	logic [COLOUR_BITS-1:0] colour_q;
	logic                   last_q;

	logic                   root_start;
	logic [RAD_SQ_BITS-1:0] root_rad;
	logic                   root_done;
	logic [RADIUS_BITS-1:0] root;

	logic                     emit;
	logic                     out_free;
	logic [SPAN_IDX_BITS-1:0] last_idx;
	logic                     is_last;
	logic [W-1:0]             cx_w, cy_w, ox_w, ix_w, dy_w;
	logic [W-1:0]             xs_d, xe_d, row_d;
	logic                     lower_row;

	asr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (root_rad),
		.done     (root_done),
		.root     (root)
	);

	// span count per row: two pieces with a hole, two rows unless dy is zero
	always_comb begin
		if (job_q.use_inner) last_idx = (job_q.dy != '0) ? SPAN_IDX_BITS'(3) : SPAN_IDX_BITS'(1);
		else last_idx = (job_q.dy != '0) ? SPAN_IDX_BITS'(1) : SPAN_IDX_BITS'(0);
		is_last  = (k_q == last_idx);
		out_free = !out_valid_q || !span_stall;
	end

	// span geometry, modulo the output width
	always_comb begin
		cx_w = {ctr_col[COORD_BITS-1], ctr_col};
		cy_w = {ctr_row[COORD_BITS-1], ctr_row};
		ox_w = W'(ox_q);
		ix_w = W'(ix_q);
		dy_w = W'(job_q.dy);
		lower_row = job_q.use_inner ? k_q[1] : k_q[0];
		row_d = lower_row ? (cy_w + dy_w) : (cy_w - dy_w);
		if (!job_q.use_inner) begin
			xs_d = cx_w - ox_w;
			xe_d = cx_w + ox_w;
		end else if (k_q[0]) begin
			xs_d = cx_w + ix_w;
			xe_d = cx_w + ox_w;
		end else begin
			xs_d = cx_w - ox_w;
			xe_d = cx_w - ix_w;
		end
	end

	// sequencer: outer root, optional inner root, then the spans
	always_comb begin
		state_d    = state_q;
		job_pop    = 1'b0;
		root_start = 1'b0;
		root_rad   = job.rad_outer;
		emit       = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop    = 1'b1;
					root_start = 1'b1;
					state_d    = BK_ROOT_OUTER;
				end
			end
			BK_ROOT_OUTER: begin
				if (root_done) begin
					if (job_q.use_inner) begin
						root_start = 1'b1;
						root_rad   = job_q.rad_inner;
						state_d    = BK_ROOT_INNER;
					end else begin
						state_d = BK_EMIT;
					end
				end
			end
			BK_ROOT_INNER: begin
				if (root_done) state_d = BK_EMIT;
			end
			BK_EMIT: begin
				emit = out_free;
				if (out_free && is_last) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE) k_q <= '0;
			else if (emit) k_q <= k_q + SPAN_IDX_BITS'(1);
			if (emit) out_valid_q <= 1'b1;
			else if (!span_stall) out_valid_q <= 1'b0;
		end
	end

	// row job, roots and the output register
	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
		if (state_q == BK_ROOT_OUTER && root_done) ox_q <= root;
		if (state_q == BK_ROOT_INNER && root_done) ix_q <= root;
		if (emit) begin
			xs_q     <= xs_d;
			xe_q     <= xe_d;
			row_q    <= row_d;
			colour_q <= colour;
			last_q   <= is_last;
		end
	end

	assign span_valid   = out_valid_q;
	assign span_x_start = xs_q;
	assign span_x_end   = xe_q;
	assign span_row     = row_q;
	assign span_colour  = colour_q;
	assign last_span    = last_q;

endmodule

@@ design/annulus_span_rasterizer.sv @@
// Annulus span rasterizer: one row offset in, up to four colored spans out.
// Each row first waits for its outer square root and, when the row crosses the hole,
// for its inner one; its spans then leave one per cycle while the output is not stalled.
// Rows are worked through one at a time by the one shared 8-step square-root unit, with
// a two-entry queue in front of it; rows with no spans are dropped before the queue.
// Reset clears the configuration registers to zero, empties the row queue and the output.
`timescale 1ns / 1ps
module annulus_span_rasterizer import asr_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_BITS-1:0]          paddr,
	input  logic [DATA_BITS-1:0]          pwdata,
	output logic [DATA_BITS-1:0]          prdata,
	output logic                          pready,
	// rows in
	input  logic                          row_valid,
	output logic                          row_stall,
	input  logic [RADIUS_BITS-1:0]        row_offset,
	// spans out
	output logic                          span_valid,
	input  logic                          span_stall,
	output logic signed [COORD_BITS:0]    span_x_start,
	output logic signed [COORD_BITS:0]    span_x_end,
	output logic signed [COORD_BITS:0]    span_row,
	output logic [COLOUR_BITS-1:0]        span_colour,
	output logic                          last_span
);

	logic [COORD_BITS-1:0]  ctr_col_q;
	logic [COORD_BITS-1:0]  ctr_row_q;
	logic [RADIUS_BITS-1:0] hole_rad_q;
	logic [RADIUS_BITS-1:0] rim_rad_q;
	logic [RGB_BITS-1:0]    fill_rgb_q;

	logic                    cfg_write;
	logic [REG_IDX_BITS-1:0] reg_idx;

	logic     q_push, q_pop, q_valid, q_full;
	row_job_t q_in, q_head;

	// register file
	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_BITS-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_col_q  <= '0;
			ctr_row_q  <= '0;
			hole_rad_q <= '0;
			rim_rad_q  <= '0;
			fill_rgb_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_CTR_COL:  ctr_col_q  <= pwdata[COORD_BITS-1:0];
				REG_CTR_ROW:  ctr_row_q  <= pwdata[COORD_BITS-1:0];
				REG_HOLE_RAD: hole_rad_q <= pwdata[RADIUS_BITS-1:0];
				REG_RIM_RAD:  rim_rad_q  <= pwdata[RADIUS_BITS-1:0];
				REG_FILL_RGB: fill_rgb_q <= pwdata[RGB_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read back, centers sign-extended
	always_comb begin
		unique case (reg_idx)
			REG_CTR_COL:  prdata = {{(DATA_BITS-COORD_BITS){ctr_col_q[COORD_BITS-1]}}, ctr_col_q};
			REG_CTR_ROW:  prdata = {{(DATA_BITS-COORD_BITS){ctr_row_q[COORD_BITS-1]}}, ctr_row_q};
			REG_HOLE_RAD: prdata = DATA_BITS'(hole_rad_q);
			REG_RIM_RAD:  prdata = DATA_BITS'(rim_rad_q);
			REG_FILL_RGB: prdata = DATA_BITS'(fill_rgb_q);
			default:      prdata = '0;
		endcase
	end

	asr_front u_front (
		.row_valid  (row_valid),
		.row_offset (row_offset),
		.row_stall  (row_stall),
		.hole_rad   (hole_rad_q),
		.rim_rad    (rim_rad_q),
		.q_full     (q_full),
		.push       (q_push),
		.job        (q_in)
	);

	asr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.valid     (q_valid),
		.full      (q_full),
		.head      (q_head)
	);

	asr_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_valid),
		.job          (q_head),
		.job_pop      (q_pop),
		.ctr_col      (ctr_col_q),
		.ctr_row      (ctr_row_q),
		.colour       (pack_rgb555(fill_rgb_q)),
		.span_valid   (span_valid),
		.span_stall   (span_stall),
		.span_x_start (span_x_start),
		.span_x_end   (span_x_end),
		.span_row     (span_row),
		.span_colour  (span_colour),
		.last_span    (last_span)
	);

	// queue never written when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push) else $error("row queue overflow");

	// back end never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("row queue underflow");

	// spans of one row leave without gaps once the sink takes them
	a_span_burst: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !span_stall && !last_span |=> span_valid)
		else $error("gap inside a row's span burst");

endmodule

@@ tb/tb_annulus_span_rasterizer.sv @@
`timescale 1ns / 1ps

// One span as it leaves the rasterizer
typedef struct packed {
	logic signed [12:0] xs;
	logic signed [12:0] xe;
	logic signed [12:0] row;
	logic [15:0]        colour;
	logic               last;
} ring_span_t;

// Keeps a copy of the ring registers, works out the spans of each accepted row
// and holds them until the block hands them out.
class ring_span_book;
	logic [11:0] cx;
	logic [11:0] cy;
	logic [7:0]  inner;
	logic [7:0]  outer;
	logic [23:0] rgb;
	ring_span_t  spans_due[$];
	ring_span_t  fresh[$];
	int          errors;

	function new();
		cx = '0;
		cy = '0;
		inner = '0;
		outer = '0;
		rgb = '0;
		errors = 0;
	endfunction

	function void set_reg(asr_pkg::reg_index_t idx, logic [31:0] v);
		case (idx)
			asr_pkg::REG_CTR_COL:  cx = v[11:0];
			asr_pkg::REG_CTR_ROW:  cy = v[11:0];
			asr_pkg::REG_HOLE_RAD: inner = v[7:0];
			asr_pkg::REG_RIM_RAD:  outer = v[7:0];
			asr_pkg::REG_FILL_RGB: rgb = v[23:0];
			default: ;
		endcase
	endfunction

	// largest root with root*root <= n, one bit at a time from the top
	function int root_floor(int n);
		int root;
		int b;
		int t;
		root = 0;
		for (b = 7; b >= 0; b--) begin
			t = root | (1 << b);
			if (t * t <= n) root = t;
		end
		return root;
	endfunction

	function void add_span(int xs, int xe, int row, logic [15:0] colour);
		ring_span_t s;
		s.xs = 13'(xs);
		s.xe = 13'(xe);
		s.row = 13'(row);
		s.colour = colour;
		s.last = 1'b0;
		fresh.push_back(s);
	endfunction

	// spans of one row offset under the current registers, left in fresh
	function int trace_row(logic [7:0] dy);
		int ro, ri, d, x0, y0, ox, ix, r, nrows, row;
		logic [15:0] colour;
		fresh.delete();
		ro = (outer > asr_pkg::MAX_RADIUS) ? asr_pkg::MAX_RADIUS : outer;
		ri = (inner > asr_pkg::MAX_RADIUS) ? asr_pkg::MAX_RADIUS : inner;
		d = dy;
		// empty ring or row outside it
		if (ro == 0 || ri >= ro || d > ro) return 0;
		x0 = $signed(cx);
		y0 = $signed(cy);
		colour = 16'h8000 | (16'(rgb[23:16] >> 3) << 10) | (16'(rgb[15:8] >> 3) << 5)
			| 16'(rgb[7:0] >> 3);
		ox = root_floor(ro * ro - d * d);
		ix = (d <= ri) ? root_floor(ri * ri - d * d) : 0;
		// center row is drawn once
		nrows = (d != 0) ? 2 : 1;
		for (r = 0; r < nrows; r++) begin
			row = (r == 0) ? y0 - d : y0 + d;
			if (d <= ri) begin
				add_span(x0 - ox, x0 - ix, row, colour);
				add_span(x0 + ix, x0 + ox, row, colour);
			end else begin
				add_span(x0 - ox, x0 + ox, row, colour);
			end
		end
		fresh[fresh.size() - 1].last = 1'b1;
		return fresh.size();
	endfunction

	function void note_row(logic [7:0] dy);
		int n;
		int i;
		n = trace_row(dy);
		for (i = 0; i < n; i++) spans_due.push_back(fresh[i]);
	endfunction

	function int pending();
		return spans_due.size();
	endfunction

	task report(string msg);
		// keep the log short if the block goes badly wrong
		if (errors < 40) $display("mismatch: %s", msg);
		errors++;
	endtask

	task check_span(logic [12:0] xs, logic [12:0] xe, logic [12:0] row, logic [15:0] colour,
			logic last);
		ring_span_t got;
		ring_span_t want;
		got.xs = xs;
		got.xe = xe;
		got.row = row;
		got.colour = colour;
		got.last = last;
		if (spans_due.size() == 0) begin
			report($sformatf("span x %0d..%0d row %0d with nothing expected",
				got.xs, got.xe, got.row));
		end else begin
			want = spans_due.pop_front();
			if (got.xs !== want.xs || got.xe !== want.xe || got.row !== want.row ||
					got.colour !== want.colour || got.last !== want.last)
				report($sformatf("span x %0d..%0d row %0d col %h last %b, want x %0d..%0d row %0d col %h last %b",
					got.xs, got.xe, got.row, got.colour, got.last,
					want.xs, want.xe, want.row, want.colour, want.last));
		end
	endtask
endclass

module tb_annulus_span_rasterizer;
	import asr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ROWS = 370;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_BITS-1:0]   paddr;
	logic [DATA_BITS-1:0]   pwdata;
	logic [DATA_BITS-1:0]   prdata;
	logic                   pready;
	logic                   row_valid;
	logic                   row_stall;
	logic [RADIUS_BITS-1:0] row_offset;
	logic                   span_valid;
	logic                   span_stall;
	logic signed [12:0]     span_x_start;
	logic signed [12:0]     span_x_end;
	logic signed [12:0]     span_row;
	logic [COLOUR_BITS-1:0] span_colour;
	logic                   last_span;

	ring_span_book book;
	int  cycles;
	int  burst_left;
	bit  hold_req;

	annulus_span_rasterizer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.row_valid    (row_valid),
		.row_stall    (row_stall),
		.row_offset   (row_offset),
		.span_valid   (span_valid),
		.span_stall   (span_stall),
		.span_x_start (span_x_start),
		.span_x_end   (span_x_end),
		.span_row     (span_row),
		.span_colour  (span_colour),
		.last_span    (last_span)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// watch both channels: note accepted rows, check every span transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (row_valid && !row_stall) book.note_row(row_offset);
			if (span_valid && !span_stall)
				book.check_span(span_x_start, span_x_end, span_row, span_colour, last_span);
		end
	end

	// receiver: random stall patterns of random length, plus one long hold-off
	initial begin : receiver
		int mode;
		int len;
		int k;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(16, 160);
			for (k = 0; k < len; k++) begin
				if (hold_req) begin
					span_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_req = 1'b0;
				end
				case (mode)
					0: span_stall <= 1'b0;
					1: span_stall <= ($urandom_range(0, 3) == 0);
					2: span_stall <= ($urandom_range(0, 3) != 0);
					default: span_stall <= ((k % 5) < 2);
				endcase
				@(posedge clk);
			end
		end
	end

	// register write: setup, then access until pready, then back to idle
	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.set_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// offer one row; bursts of rows separated by random gaps
	task automatic push_row(input logic [7:0] dy);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				row_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		row_valid <= 1'b1;
		row_offset <= dy;
		do @(posedge clk); while (row_stall);
	endtask

	// let the block drain before touching registers again
	task automatic quiesce();
		row_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_ring(input logic [31:0] x, input logic [31:0] y, input logic [7:0] ri,
			input logic [7:0] ro, input logic [31:0] rgb);
		write_reg(REG_CTR_COL, x);
		write_reg(REG_CTR_ROW, y);
		write_reg(REG_HOLE_RAD, {24'h0, ri});
		write_reg(REG_RIM_RAD, {24'h0, ro});
		write_reg(REG_FILL_RGB, rgb);
	endtask

	initial begin : stimulus
		int made;
		int got;
		int sent;
		int cap;
		int pick;
		int ro;
		int ri;
		bit ring_ok;
		bit held;
		logic [7:0] dy;

		book = new();
		burst_left = 0;
		hold_req = 1'b0;
		held = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		row_valid <= 1'b0;
		row_offset <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: outer radius zero draws nothing
		push_row(8'd0);
		push_row(8'd255);
		quiesce();

		// small ring: center row, row on the hole edge, past the hole, outer edge, beyond
		set_ring(32'd0, 32'd0, 8'd3, 8'd10, 32'h00FF_FFFF);
		push_row(8'd0);
		push_row(8'd3);
		push_row(8'd4);
		push_row(8'd10);
		push_row(8'd11);
		push_row(8'd255);
		quiesce();

		// widest coordinates, no hole
		set_ring(32'hFFFF_F800, 32'h0000_07FF, 8'd0, 8'd255, 32'h0000_0000);
		push_row(8'd0);
		push_row(8'd1);
		push_row(8'd128);
		push_row(8'd254);
		push_row(8'd255);
		quiesce();

		// hole as wide as the ring: nothing drawn
		set_ring(32'h0000_07FF, 32'h0000_0800, 8'd255, 8'd255, 32'h00A5_C3F8);
		push_row(8'd0);
		push_row(8'd100);
		quiesce();
		// thinnest ring of the largest size
		write_reg(REG_HOLE_RAD, 32'd254);
		push_row(8'd0);
		push_row(8'd254);
		push_row(8'd255);
		quiesce();

		// hole larger than the ring
		set_ring(32'd17, 32'd33, 8'd200, 8'd100, 32'h0012_3456);
		push_row(8'd50);
		quiesce();

		// smallest ring
		set_ring(32'd5, 32'hFFFF_FFFB, 8'd0, 8'd1, 32'h00FF_0000);
		push_row(8'd0);
		push_row(8'd1);
		push_row(8'd2);
		quiesce();

		// random rings: mostly rows that land inside, some noise
		made = 0;
		while (made < RANDOM_ROWS) begin
			pick = $urandom_range(0, 9);
			ro = $urandom_range(1, 255);
			if (pick == 0) ri = $urandom_range(ro, 255);
			else if (pick == 1) begin
				ro = 0;
				ri = $urandom_range(0, 255);
			end else if (pick == 2) ri = 0;
			else ri = $urandom_range(0, ro - 1);
			ring_ok = (ro != 0) && (ri < ro);
			set_ring($urandom(), $urandom(), 8'(ri), 8'(ro), $urandom());
			// the first drawing ring runs against a long output hold-off
			if (ring_ok && !held) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			got = 0;
			sent = 0;
			cap = ring_ok ? 70 : 12;
			while (got < 46 && sent < cap) begin
				pick = $urandom_range(0, 9);
				if (ring_ok && pick < 4 && ri > 0) dy = 8'($urandom_range(0, ri));
				else if (ring_ok && pick < 8) dy = 8'($urandom_range(0, ro));
				else dy = 8'($urandom_range(0, 255));
				if (book.trace_row(dy) > 0) got++;
				push_row(dy);
				sent++;
			end
			made += sent;
			quiesce();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.pending() != 0)
			book.report($sformatf("%0d spans never arrived", book.pending()));
		if (book.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
